[rtl/acss_pkg.sv]
// ============================================================================
// ADC channel scan sequencer package
// Shared widths, setting field positions and the channel-advance function.
// ============================================================================
package acss_pkg;

    localparam int NUM_CHANNELS  = 8;
    localparam int SETTING_COUNT = 8;
    localparam int CHAN_W        = 3;
    localparam int SAMPLE_W      = 10;
    localparam int SETTING_W     = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int TRY_W         = $clog2(NUM_CHANNELS + 1);

    // Bit positions inside one channel setting.
    localparam int SEL_MUX_LSB = 0;
    localparam int SEL_MUX_W   = 3;
    localparam int SEL_REF_BIT = 3;
    localparam int SEL_EN_BIT  = 4;

    typedef logic [CHAN_W-1:0]    t_chan;
    typedef logic [SETTING_W-1:0] t_setting;
    typedef logic [SAMPLE_W-1:0]  t_sample;
    typedef logic [TRY_W-1:0]     t_tries;

    // Step to the next channel, wrapping to zero at NUM_CHANNELS.
    function automatic t_chan advance_chan(input t_chan ch);
        logic [CHAN_W:0] n;
        n = {1'b0, ch} + {{CHAN_W{1'b0}}, 1'b1};
        if (n >= (CHAN_W + 1)'(NUM_CHANNELS)) begin
            n = '0;
        end
        return n[CHAN_W-1:0];
    endfunction

endpackage

[rtl/adc_channel_scan_sequencer_unit.sv]
// ============================================================================
// ADC channel scan sequencer
// Round-robin scanner: tags each finished sample with its channel and picks
// the next enabled channel (or the next channel when none is enabled) for the following conversion.
// ============================================================================
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+--------------------------------
//  input   | in        | i_in_valid / o_in_stall    | i_sample_value
//  output  | out       | o_out_valid / i_out_stall  | o_stored_value, o_stored_channel,
//          |           |                            | o_next_channel, o_mux_select,
//          |           |                            | o_ref_internal
//  config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An item is accepted in the idle state; the search then tests one candidate
// channel per step (1 to NUM_CHANNELS + 1 steps), and the result waits in the
// output register until it is taken.
// The search is a single shared advance-and-test step run under a small
// sequencer. The block takes no new item until the result has been taken.
// Reset is synchronous and active low; it clears the channel history, the
// channel settings and the sequencer. A stall on the output holds the result.
//
module adc_channel_scan_sequencer_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  acss_pkg::t_sample       i_sample_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output acss_pkg::t_sample       o_stored_value,
    output acss_pkg::t_chan         o_stored_channel,
    output acss_pkg::t_chan         o_next_channel,
    output logic [2:0]              o_mux_select,
    output logic                    o_ref_internal,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  acss_pkg::t_setting      i_cfg_data
);
    import acss_pkg::*;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_OUT    = 2'd2;

    logic [1:0] r_state, n_state;

    // Channel history.
    t_chan r_current_chan, n_current_chan;
    t_chan r_last_chan,    n_last_chan;
    t_chan r_older_chan,   n_older_chan;

    // Search state: the candidate channel and how many extra advances were made.
    t_chan  r_cand,  n_cand;
    t_tries r_tries, n_tries;

    // Channel setting registers.
    t_setting r_setting [SETTING_COUNT];

    // Result register.
    t_sample          r_stored_value, n_stored_value;
    t_chan            r_stored_chan,  n_stored_chan;
    logic [SEL_MUX_W-1:0] r_mux, n_mux;
    logic             r_ref,          n_ref;

    logic     in_accept;
    logic     out_accept;
    t_setting cand_setting;
    logic     search_done;

    assign in_accept    = i_in_valid && (r_state == ST_IDLE);
    assign out_accept   = (r_state == ST_OUT) && !i_out_stall;
    assign cand_setting = r_setting[r_cand];

    // The search stops at the first enabled candidate, or after NUM_CHANNELS
    // extra advances when no channel is enabled at all.
    assign search_done  = cand_setting[SEL_EN_BIT] ||
                          (r_tries == TRY_W'(NUM_CHANNELS));

    always_comb begin
        n_state        = r_state;
        n_current_chan = r_current_chan;
        n_last_chan    = r_last_chan;
        n_older_chan   = r_older_chan;
        n_cand         = r_cand;
        n_tries        = r_tries;
        n_stored_value = r_stored_value;
        n_stored_chan  = r_stored_chan;
        n_mux          = r_mux;
        n_ref          = r_ref;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    // The first advance is unconditional.
                    n_stored_value = i_sample_value;
                    n_cand         = advance_chan(r_current_chan);
                    n_tries        = '0;
                    n_state        = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (search_done) begin
                    // Shift the history and commit the new channel. The
                    // sample belongs to the channel two steps back.
                    n_older_chan   = r_last_chan;
                    n_last_chan    = r_current_chan;
                    n_current_chan = r_cand;
                    n_stored_chan  = r_last_chan;
                    n_mux          = cand_setting[SEL_MUX_LSB +: SEL_MUX_W];
                    n_ref          = cand_setting[SEL_REF_BIT];
                    n_state        = ST_OUT;
                end else begin
                    n_cand  = advance_chan(r_cand);
                    n_tries = r_tries + 1'b1;
                end
            end
            ST_OUT: begin
                if (out_accept) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_current_chan <= '0;
            r_last_chan    <= '0;
            r_older_chan   <= '0;
            r_cand         <= '0;
            r_tries        <= '0;
        end else begin
            r_state        <= n_state;
            r_current_chan <= n_current_chan;
            r_last_chan    <= n_last_chan;
            r_older_chan   <= n_older_chan;
            r_cand         <= n_cand;
            r_tries        <= n_tries;
        end
    end

    // Settings reset to zero, so every channel starts disabled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SETTING_COUNT; i++) begin
                r_setting[i] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_setting[i_cfg_index] <= i_cfg_data;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_stored_value <= n_stored_value;
        r_stored_chan  <= n_stored_chan;
        r_mux          <= n_mux;
        r_ref          <= n_ref;
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = (r_state == ST_OUT);
    assign o_stored_value   = r_stored_value;
    assign o_stored_channel = r_stored_chan;
    assign o_next_channel   = r_current_chan;
    assign o_mux_select     = r_mux;
    assign o_ref_internal   = r_ref;
    assign o_cfg_ready      = 1'b1;

endmodule

[tb/sv/testbench.sv]
// ============================================================================
// ADC channel scan sequencer testbench
// Drives sample items through the scanner under several channel settings,
// predicts each result from a shadow copy of the settings and channel history,
// and checks every result field by field with random gaps and output stalls.
// ============================================================================
module testbench;

    import acss_pkg::*;

    // One expected result item, at the widths of the output ports.
    typedef struct packed {
        t_sample    value;
        t_chan      tag_chan;
        t_chan      next_chan;
        logic [2:0] mux;
        logic       int_ref;
    } t_scan_result;

    // Clock and reset. Reset is synchronous, so it is held across several edges.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Every input of the block starts at a known value.
    logic                 i_in_valid     = 1'b0;
    t_sample              i_sample_value = '0;
    logic                 i_out_stall    = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    t_setting             i_cfg_data     = '0;

    logic       o_in_stall;
    logic       o_out_valid;
    t_sample    o_stored_value;
    t_chan      o_stored_channel;
    t_chan      o_next_channel;
    logic [2:0] o_mux_select;
    logic       o_ref_internal;
    logic       o_cfg_ready;

    adc_channel_scan_sequencer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sample_value  (i_sample_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_stored_value  (o_stored_value),
        .o_stored_channel(o_stored_channel),
        .o_next_channel  (o_next_channel),
        .o_mux_select    (o_mux_select),
        .o_ref_internal  (o_ref_internal),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Samples waiting to be sent, and results predicted but not yet seen.
    t_sample      pending_samples[$];
    t_scan_result expected_scans[$];

    // Shadow of the channel settings and of the three-deep channel history.
    t_setting shadow_setting[SETTING_COUNT];
    t_chan    hist_cur;
    t_chan    hist_last;
    t_chan    hist_older;

    // Settings that the next configuration phase will write.
    t_setting plan_setting[SETTING_COUNT];

    int  mismatch_count = 0;
    int  send_gap       = 0;
    int  stall_left     = 0;
    // When set, neither side idles, so items go back to back.
    bit  calm           = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Round-robin step with wrap at the channel count.
    function automatic t_chan wrap_next(input t_chan ch);
        if (int'(ch) + 1 >= NUM_CHANNELS) begin
            return '0;
        end
        return ch + 1'b1;
    endfunction

    // Shift the history, search for the next enabled channel and build the
    // result. The search gives up after a full lap, which leaves the channel
    // one past where it started when nothing is enabled.
    function automatic t_scan_result scan_predict(input t_sample sample);
        t_scan_result r;
        t_chan        c;
        t_setting     s;
        int           tries;
        hist_older = hist_last;
        hist_last  = hist_cur;
        c = wrap_next(hist_cur);
        for (tries = 0; tries < NUM_CHANNELS && !shadow_setting[c][SEL_EN_BIT]; tries++) begin
            c = wrap_next(c);
        end
        hist_cur    = c;
        s           = shadow_setting[c];
        r.value     = sample;
        r.tag_chan  = hist_older;
        r.next_chan = c;
        r.mux       = s[SEL_MUX_LSB +: SEL_MUX_W];
        r.int_ref   = s[SEL_REF_BIT];
        return r;
    endfunction

    // Idle lengths: mostly short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Input driver. A stalled item is held unchanged; after an item is taken
    // the driver waits out its gap before offering the next one. Each step
    // makes exactly one assignment to i_in_valid.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_scans.push_back(scan_predict(i_sample_value));
            end
            if (i_in_valid && o_in_stall) begin
                i_in_valid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                i_sample_value <= pending_samples.pop_front();
                i_in_valid     <= 1'b1;
                send_gap = idle_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output monitor. Each taken result is matched against the oldest
    // prediction; the stall line is driven in random bursts.
    always @(posedge i_clk) begin
        t_scan_result want;
        int           n;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_scans.size() == 0) begin
                    report_mismatch("unexpected result, next channel", o_next_channel, -1);
                end else begin
                    want = expected_scans.pop_front();
                    check_field("stored value", o_stored_value, want.value);
                    check_field("stored channel", o_stored_channel, want.tag_chan);
                    check_field("next channel", o_next_channel, want.next_chan);
                    check_field("mux select", o_mux_select, want.mux);
                    check_field("internal reference", o_ref_internal, want.int_ref);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                n = idle_len();
                if (n > 0) begin
                    stall_left = n - 1;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // Wait until every queued item has gone in and every result has come out,
    // then give the block a little longer than its worst latency to settle.
    task automatic drain();
        while (pending_samples.size() != 0 || i_in_valid || expected_scans.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
    endtask

    // One register write over the configuration channel. The shadow copy is
    // updated at the edge where the write is taken.
    task automatic write_setting(input int idx, input t_setting data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_IDX_W'(idx);
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        shadow_setting[idx] = data;
        i_cfg_valid <= 1'b0;
    endtask

    // Settings are only changed with the block idle.
    task automatic apply_plan();
        int i;
        drain();
        for (i = 0; i < SETTING_COUNT; i++) begin
            write_setting(i, plan_setting[i]);
        end
    endtask

    // A disabled setting with random mux and reference bits, which matter
    // only when no channel is enabled at all.
    function automatic t_setting off_setting();
        t_setting s;
        s = t_setting'($urandom_range(0, 31));
        s[SEL_EN_BIT] = 1'b0;
        return s;
    endfunction

    task automatic plan_random();
        int i;
        int mode;
        int pick;
        mode = $urandom_range(0, 5);
        pick = $urandom_range(0, SETTING_COUNT - 1);
        for (i = 0; i < SETTING_COUNT; i++) begin
            case (mode)
                0, 5: plan_setting[i] = t_setting'($urandom_range(0, 31));
                1: plan_setting[i] = off_setting();
                2: begin
                    plan_setting[i] = off_setting();
                    if (i == pick) begin
                        plan_setting[i][SEL_EN_BIT] = 1'b1;
                    end
                end
                3: begin
                    plan_setting[i] = t_setting'($urandom_range(0, 31));
                    plan_setting[i][SEL_EN_BIT] = 1'b1;
                end
                default: plan_setting[i] = ($urandom_range(0, 1) != 0) ? '1 : '0;
            endcase
        end
    endtask

    initial begin
        int i;
        int p;
        int count;
        for (i = 0; i < SETTING_COUNT; i++) begin
            shadow_setting[i] = '0;
        end
        hist_cur   = '0;
        hist_last  = '0;
        hist_older = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: no channel is enabled, so each item moves the
        // channel on by exactly one. Sample extremes and alternating bits.
        pending_samples.push_back('0);
        pending_samples.push_back('1);
        pending_samples.push_back(10'h155);
        pending_samples.push_back(10'h2AA);

        // Every channel enabled with all mux and reference bits set.
        for (i = 0; i < SETTING_COUNT; i++) begin
            plan_setting[i] = '1;
        end
        apply_plan();
        for (i = 0; i < 3; i++) begin
            pending_samples.push_back(t_sample'($urandom_range(0, 1023)));
        end

        // Only the last channel enabled: every search wraps and lands on it.
        for (i = 0; i < SETTING_COUNT; i++) begin
            plan_setting[i] = 5'b01111;
        end
        plan_setting[SETTING_COUNT - 1] = 5'b10101;
        apply_plan();
        for (i = 0; i < 3; i++) begin
            pending_samples.push_back(t_sample'($urandom_range(0, 1023)));
        end

        // Only channel zero enabled, with internal reference.
        for (i = 0; i < SETTING_COUNT; i++) begin
            plan_setting[i] = '0;
        end
        plan_setting[0] = 5'b11010;
        apply_plan();
        for (i = 0; i < 3; i++) begin
            pending_samples.push_back(t_sample'($urandom_range(0, 1023)));
        end

        // Nothing enabled again, but the disabled settings carry mux and
        // reference bits that must show up on the outputs.
        for (i = 0; i < SETTING_COUNT; i++) begin
            plan_setting[i] = off_setting();
        end
        apply_plan();
        for (i = 0; i < 3; i++) begin
            pending_samples.push_back(t_sample'($urandom_range(0, 1023)));
        end

        // Alternate channels enabled, so the search skips one each time.
        for (i = 0; i < SETTING_COUNT; i++) begin
            plan_setting[i] = t_setting'($urandom_range(0, 15));
            plan_setting[i][SEL_EN_BIT] = i[0];
        end
        apply_plan();
        for (i = 0; i < 3; i++) begin
            pending_samples.push_back(t_sample'($urandom_range(0, 1023)));
        end

        // Random phases, each with fresh settings; every fourth phase runs
        // without gaps or stalls.
        for (p = 0; p < 20; p++) begin
            plan_random();
            apply_plan();
            calm = (p % 4 == 3);
            count = $urandom_range(40, 62);
            for (i = 0; i < count; i++) begin
                pending_samples.push_back(t_sample'($urandom_range(0, 1023)));
            end
        end

        drain();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
